### src/uslang_pkg.sv
`timescale 1ns / 1ps
// uslang_pkg: types, constants and decode/classify functions for the
// UTF-8 script and language detector. No dependencies.
package uslang_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } text_in_t;

  typedef struct packed {
    logic [2:0] language;
    logic [4:0] scripts_seen;
  } result_t;

  typedef enum logic [2:0] {
    LANG_EN = 3'd0,
    LANG_ZH = 3'd1,
    LANG_RU = 3'd2,
    LANG_JA = 3'd3,
    LANG_KO = 3'd4
  } lang_e;

  typedef enum logic {
    ST_STREAM = 1'b0,
    ST_FLUSH  = 1'b1
  } state_e;

  typedef struct packed {
    logic step_in;
    logic flush_step;
    logic load_out;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic tail_pending;
    logic flush_last;
  } status_t;

  localparam int unsigned CpW = 21;

  localparam int unsigned FlagLatin    = 0;
  localparam int unsigned FlagKana     = 1;
  localparam int unsigned FlagHangul   = 2;
  localparam int unsigned FlagCyrillic = 3;
  localparam int unsigned FlagHan      = 4;

  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    priority if (b[7] == 1'b0)          len = 3'd1;
    else if (b[7:5] == 3'b110)          len = 3'd2;
    else if (b[7:4] == 4'b1110)         len = 3'd3;
    else if (b[7:3] == 5'b11110)        len = 3'd4;
    else                                len = 3'd1;
    return len;
  endfunction

  function automatic logic [CpW-1:0] decode(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3,
                                            input logic [2:0] len);
    logic [CpW-1:0] cp;
    unique case (len)
      3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
      3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default: cp = {13'd0, b0};
    endcase
    return cp;
  endfunction

  function automatic logic in_rng(input logic [CpW-1:0] cp, input logic [CpW-1:0] lo,
                                  input logic [CpW-1:0] hi);
    return (cp >= lo) && (cp <= hi);
  endfunction

  // first matching class wins
  function automatic logic [4:0] classify(input logic [CpW-1:0] cp);
    logic [4:0] f;
    f = '0;
    priority if (in_rng(cp, 21'h00041, 21'h0005A) || in_rng(cp, 21'h00061, 21'h0007A) ||
                 in_rng(cp, 21'h000C0, 21'h0024F)) begin
      f[FlagLatin] = 1'b1;
    end else if (in_rng(cp, 21'h03040, 21'h030FF) || in_rng(cp, 21'h031F0, 21'h031FF)) begin
      f[FlagKana] = 1'b1;
    end else if (in_rng(cp, 21'h0AC00, 21'h0D7AF) || in_rng(cp, 21'h01100, 21'h011FF) ||
                 in_rng(cp, 21'h03130, 21'h0318F)) begin
      f[FlagHangul] = 1'b1;
    end else if (in_rng(cp, 21'h00400, 21'h0052F)) begin
      f[FlagCyrillic] = 1'b1;
    end else if (in_rng(cp, 21'h04E00, 21'h09FFF) || in_rng(cp, 21'h03400, 21'h04DBF) ||
                 in_rng(cp, 21'h20000, 21'h2A6DF) || in_rng(cp, 21'h0F900, 21'h0FAFF) ||
                 in_rng(cp, 21'h2F800, 21'h2FA1F)) begin
      f[FlagHan] = 1'b1;
    end else begin
      f = '0;
    end
    return f;
  endfunction

  function automatic lang_e pick_language(input logic [4:0] f);
    lang_e l;
    priority if (f[FlagKana])     l = LANG_JA;
    else if (f[FlagHangul])       l = LANG_KO;
    else if (f[FlagCyrillic])     l = LANG_RU;
    else if (f[FlagHan])          l = LANG_ZH;
    else                          l = LANG_EN;
    return l;
  endfunction

endpackage

### src/uslang_ctrl.sv
`timescale 1ns / 1ps
// uslang_ctrl: stream/flush state machine and output valid register.
// Depends on uslang_pkg.
module uslang_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output uslang_pkg::cmd_t    cmd_o,
  input  uslang_pkg::status_t stat_i
);

  uslang_pkg::state_e state_q, state_d;
  logic               out_valid_q, out_valid_d;
  logic               out_ready;

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      uslang_pkg::ST_STREAM: begin
        in_stall_o = !out_ready;
        if (in_valid_i && out_ready) begin
          cmd_o.step_in = 1'b1;
          if (in_last_i) begin
            if (stat_i.tail_pending) begin
              state_d = uslang_pkg::ST_FLUSH;
            end else begin
              cmd_o.load_out = 1'b1;
              cmd_o.clear    = 1'b1;
            end
          end
        end
      end
      uslang_pkg::ST_FLUSH: begin
        if (out_ready) begin
          cmd_o.flush_step = 1'b1;
          if (stat_i.flush_last) begin
            cmd_o.load_out = 1'b1;
            cmd_o.clear    = 1'b1;
            state_d        = uslang_pkg::ST_STREAM;
          end
        end
      end
    endcase
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= uslang_pkg::ST_STREAM;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### src/uslang_dp.sv
`timescale 1ns / 1ps
// uslang_dp: pending-sequence buffer, decoder, classifier, sticky flags
// and result register. Depends on uslang_pkg.
module uslang_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          text_byte_i,
  input  uslang_pkg::cmd_t    cmd_i,
  output uslang_pkg::status_t stat_o,
  output uslang_pkg::result_t result_o
);

  logic [7:0] pend_q [4];
  logic [7:0] pend_d [4];
  logic [7:0] win    [4];
  logic [2:0] count_q, count_d, count_s, count_f;
  logic [2:0] needed_q, needed_d, needed_s;
  logic [4:0] flags_q, flags_d, flags_step;
  uslang_pkg::result_t result_q;

  logic [2:0] lead_len, cnt_inc, len_f, used;
  logic       dec_ok;
  logic       cp_en;
  logic [uslang_pkg::CpW-1:0] cp;

  assign lead_len = uslang_pkg::seq_len(text_byte_i);
  assign cnt_inc  = count_q + 3'd1;
  assign len_f    = uslang_pkg::seq_len(pend_q[0]);
  assign dec_ok   = (len_f != 3'd1) && (len_f <= count_q);
  assign used     = dec_ok ? len_f : 3'd1;
  assign count_f  = count_q - used;

  // pending bytes with the incoming byte dropped into its slot
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      win[k] = (count_q == 3'(k)) ? text_byte_i : pend_q[k];
    end
  end

  always_comb begin
    pend_d   = pend_q;
    count_s  = count_q;
    needed_s = needed_q;
    cp_en    = 1'b0;
    cp       = '0;
    if (cmd_i.flush_step) begin
      cp_en   = 1'b1;
      cp      = dec_ok ? uslang_pkg::decode(pend_q[0], pend_q[1], pend_q[2], pend_q[3], len_f)
                       : {13'd0, pend_q[0]};
      count_s = count_f;
      unique case (used)
        3'd1: begin
          pend_d[0] = pend_q[1];
          pend_d[1] = pend_q[2];
          pend_d[2] = pend_q[3];
        end
        3'd2: begin
          pend_d[0] = pend_q[2];
          pend_d[1] = pend_q[3];
        end
        default: begin
          pend_d[0] = pend_q[3];
        end
      endcase
    end else if (count_q == 3'd0) begin
      if (lead_len == 3'd1) begin
        cp_en = 1'b1;
        cp    = {13'd0, text_byte_i};
      end else begin
        pend_d[0] = text_byte_i;
        count_s   = 3'd1;
        needed_s  = lead_len;
      end
    end else begin
      pend_d[count_q[1:0]] = text_byte_i;
      if ((cnt_inc >= needed_q) || cnt_inc[2]) begin
        cp_en    = 1'b1;
        cp       = uslang_pkg::decode(win[0], win[1], win[2], win[3], needed_q);
        count_s  = 3'd0;
        needed_s = 3'd0;
      end else begin
        count_s = cnt_inc;
      end
    end
  end

  assign flags_step = flags_q | (cp_en ? uslang_pkg::classify(cp) : 5'd0);

  assign stat_o.tail_pending = (count_s != 3'd0);
  assign stat_o.flush_last   = (used >= count_q);

  always_comb begin
    count_d  = count_q;
    needed_d = needed_q;
    flags_d  = flags_q;
    if (cmd_i.step_in || cmd_i.flush_step) begin
      count_d  = count_s;
      needed_d = needed_s;
      flags_d  = flags_step;
    end
    if (cmd_i.clear) begin
      count_d  = 3'd0;
      needed_d = 3'd0;
      flags_d  = 5'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 3'd0;
      needed_q <= 3'd0;
      flags_q  <= 5'd0;
    end else begin
      count_q  <= count_d;
      needed_q <= needed_d;
      flags_q  <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_in || cmd_i.flush_step) begin
      pend_q <= pend_d;
    end
    if (cmd_i.load_out) begin
      result_q.language     <= 3'(uslang_pkg::pick_language(flags_step));
      result_q.scripts_seen <= flags_step;
    end
  end

  assign result_o = result_q;

endmodule

### src/utf8_script_language_detect.sv
`timescale 1ns / 1ps
// utf8_script_language_detect: top level, controller plus datapath.
// Depends on uslang_pkg, uslang_ctrl, uslang_dp.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------
//   in      | input     | in_valid_i / in_stall_o | in_data_i  (text_in_t)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (result_t)
//
// One text byte per cycle. A final byte that leaves a sequence unfinished adds
// a tail replay, one code point per cycle through the single classifier while
// the output is not stalled. The result sits in an output register; bytes keep
// flowing while it waits, and input stalls only when that register is full and
// stalled or during the tail replay. Reset is asynchronous and needs no clearing pass.
module utf8_script_language_detect (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  uslang_pkg::text_in_t in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output uslang_pkg::result_t  out_data_o
);

  uslang_pkg::cmd_t    cmd;
  uslang_pkg::status_t stat;

  uslang_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last_byte),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  uslang_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .text_byte_i(in_data_i.text_byte),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .result_o   (out_data_o)
  );

  // a non-final byte never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && in_valid_i && !in_stall_o && !in_data_i.last_byte) |=> !out_valid_o)
    else $error("result raised by a non-final byte");

  // a final byte either yields a result next cycle or starts tail replay
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.last_byte) |=> (out_valid_o || in_stall_o))
    else $error("final byte produced neither result nor replay");

  // kana always wins the language choice
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.scripts_seen[uslang_pkg::FlagKana]) |->
      (out_data_o.language == uslang_pkg::LANG_JA))
    else $error("kana seen but language is not ja");

  // with no script flags set the language is en
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.scripts_seen == 5'd0)) |->
      (out_data_o.language == uslang_pkg::LANG_EN))
    else $error("no scripts seen but language is not en");

endmodule
